FILE: hw/rtl/grsg_pkg.sv
// Shared types and constants for the gradient row span generator.
// Used by every module of the block except the port-level checker grsg_chk; depends on nothing.
package grsg_pkg;

  localparam int unsigned DimWidth     = 14;
  localparam int unsigned CoordWidth   = 16;
  localparam int unsigned RowWidth     = 15;
  localparam int unsigned ColorWidth   = 24;
  localparam int unsigned AddrWidth    = 26;
  localparam int unsigned NumChannels  = 3;
  localparam int unsigned ChanWidth    = 8;
  localparam int unsigned QuoWidth     = 8;
  localparam int unsigned NumWidth     = ChanWidth + RowWidth;
  localparam int unsigned RemWidth     = NumWidth + 1;
  localparam int unsigned InDataWidth  = 128;
  localparam int unsigned OutDataWidth = 64;
  localparam int unsigned CfgIdxWidth  = 2;

  localparam logic [DimWidth-1:0] FbWidthRst    = 14'd640;
  localparam logic [DimWidth-1:0] FbHeightRst   = 14'd480;
  localparam logic [DimWidth-1:0] LineStrideRst = 14'd640;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgFbWidth    = 2'd0,
    CfgFbHeight   = 2'd1,
    CfgLineStride = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [DimWidth-1:0] fb_width;
    logic [DimWidth-1:0] fb_height;
    logic [DimWidth-1:0] line_stride;
  } cfg_t;

  typedef struct packed {
    logic [CoordWidth-1:0] rect_x;
    logic [CoordWidth-1:0] rect_y;
    logic [CoordWidth-1:0] rect_width;
    logic [CoordWidth-1:0] rect_height;
    logic [ColorWidth-1:0] top_color;
    logic [ColorWidth-1:0] bottom_color;
    logic [RowWidth-1:0]   row_index;
  } rect_t;

  typedef struct packed {
    logic                  ok;
    logic [DimWidth-1:0]   py;
    logic [DimWidth-1:0]   x0;
    logic [DimWidth-1:0]   len;
    logic [RowWidth-1:0]   dvs;
    logic [RowWidth-1:0]   row;
    logic [ColorWidth-1:0] top_color;
    logic [ColorWidth-1:0] bottom_color;
  } clip_t;

  typedef struct packed {
    logic                                  ok;
    logic [AddrWidth-1:0]                  addr;
    logic [DimWidth-1:0]                   len;
    logic [ColorWidth-1:0]                 top_color;
    logic [NumChannels-1:0]                neg;
    logic [RowWidth-1:0]                   dvs;
    logic [NumChannels-1:0][NumWidth-1:0]  rem;
    logic [NumChannels-1:0][QuoWidth-1:0]  quo;
  } div_t;

  typedef struct packed {
    logic [ColorWidth-1:0] row_color;
    logic [DimWidth-1:0]   span_length;
    logic [AddrWidth-1:0]  start_address;
    logic                  span_valid;
  } span_t;

endpackage

FILE: hw/rtl/gradient_row_span_generator.sv
// Channel    | Dir | Handshake                    | Payload
// s_axis     | in  | s_axis_tvalid / s_axis_tready | rectangle, colors, row index
// m_axis     | out | m_axis_tvalid / m_axis_tready | span address, length, color
// cfg        | in  | cfg_we_i                      | fb_width, fb_height, line_stride
//
// One transaction per cycle is accepted and delivered when the output is not stalled.
// Pipeline registers in order: input register, clip, multiply, eight divider stages, output.
// The eight restoring-divider stages, one quotient bit each, set the pipeline depth.
// Reset clears every stage valid bit and loads the default framebuffer geometry.
// A stall at the output fills empty stages first, so gaps in the pipe are absorbed.
// Top level of the gradient row span generator; depends on grsg_pkg and the grsg_* stages.
module gradient_row_span_generator #(
  parameter int unsigned FbMaxDim = 8192
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // tdata: rect_x[15:0], rect_y[31:16], rect_width[47:32], rect_height[63:48],
  //        top_color[87:64], bottom_color[111:88], row_index[126:112], zero pad.
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [grsg_pkg::InDataWidth-1:0]      s_axis_tdata,
  // tdata: start_address[25:0], span_length[39:26], row_color[63:40].
  // tuser: span_valid[0].
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [grsg_pkg::OutDataWidth-1:0]     m_axis_tdata,
  output logic                                  m_axis_tuser,
  input  logic                                  cfg_we_i,
  input  logic [grsg_pkg::CfgIdxWidth-1:0]      cfg_idx_i,
  input  logic [grsg_pkg::DimWidth-1:0]         cfg_wdata_i
);
  import grsg_pkg::*;

  cfg_t                cfg_d, cfg_q;
  logic [DimWidth-1:0] wdata_sat;
  rect_t               in_data;

  logic   clip_valid, clip_ready;
  clip_t  clip_data;

  logic [QuoWidth:0] div_valid;
  logic [QuoWidth:0] div_ready;
  div_t              div_data [QuoWidth+1];

  span_t  span_data;

  assign wdata_sat = ({1'b0, cfg_wdata_i} > (DimWidth+1)'(FbMaxDim))
                   ? DimWidth'(FbMaxDim) : cfg_wdata_i;

  always_comb begin
    cfg_d = cfg_q;
    unique case (cfg_reg_e'(cfg_idx_i))
      CfgFbWidth:    cfg_d.fb_width    = wdata_sat;
      CfgFbHeight:   cfg_d.fb_height   = wdata_sat;
      CfgLineStride: cfg_d.line_stride = wdata_sat;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fb_width    <= FbWidthRst;
      cfg_q.fb_height   <= FbHeightRst;
      cfg_q.line_stride <= LineStrideRst;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_d;
    end
  end

  assign in_data.rect_x       = s_axis_tdata[15:0];
  assign in_data.rect_y       = s_axis_tdata[31:16];
  assign in_data.rect_width   = s_axis_tdata[47:32];
  assign in_data.rect_height  = s_axis_tdata[63:48];
  assign in_data.top_color    = s_axis_tdata[87:64];
  assign in_data.bottom_color = s_axis_tdata[111:88];
  assign in_data.row_index    = s_axis_tdata[126:112];

  grsg_clip u_clip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  (in_data),
    .valid_o (clip_valid),
    .ready_i (clip_ready),
    .data_o  (clip_data)
  );

  grsg_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (clip_valid),
    .ready_o (clip_ready),
    .data_i  (clip_data),
    .valid_o (div_valid[0]),
    .ready_i (div_ready[0]),
    .data_o  (div_data[0])
  );

  for (genvar g = 0; g < QuoWidth; g++) begin : gen_div
    grsg_div_step #(
      .Bit (QuoWidth - 1 - g)
    ) u_div_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_valid[g]),
      .ready_o (div_ready[g]),
      .data_i  (div_data[g]),
      .valid_o (div_valid[g+1]),
      .ready_i (div_ready[g+1]),
      .data_o  (div_data[g+1])
    );
  end

  grsg_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid[QuoWidth]),
    .ready_o (div_ready[QuoWidth]),
    .data_i  (div_data[QuoWidth]),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (span_data)
  );

  assign m_axis_tdata = {span_data.row_color, span_data.span_length, span_data.start_address};
  assign m_axis_tuser = span_data.span_valid;

endmodule

FILE: hw/rtl/grsg_clip.sv
// Input register and clipping stage of the gradient row span generator.
// Depends on grsg_pkg for the configuration, input and clip types.
module grsg_clip (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  grsg_pkg::cfg_t  cfg_i,
  input  logic           valid_i,
  output logic           ready_o,
  input  grsg_pkg::rect_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output grsg_pkg::clip_t data_o
);
  import grsg_pkg::*;

  logic    in_valid_q;
  rect_t   in_q;
  logic    clip_valid_q;
  clip_t   clip_d, clip_q;
  logic    clip_ready;

  logic [CoordWidth:0]   py_s;
  logic [CoordWidth:0]   xe_s;
  logic [DimWidth-1:0]   x0;
  logic [DimWidth-1:0]   x1;
  logic                  ok_h;
  logic                  ok_y;
  logic                  ok_x;

  assign clip_ready = !clip_valid_q || ready_i;
  assign ready_o    = !in_valid_q || clip_ready;

  always_comb begin
    py_s = {in_q.rect_y[CoordWidth-1], in_q.rect_y} + {2'b00, in_q.row_index};
    xe_s = {in_q.rect_x[CoordWidth-1], in_q.rect_x}
         + {in_q.rect_width[CoordWidth-1], in_q.rect_width};

    ok_h = !in_q.rect_height[CoordWidth-1] && (in_q.rect_height != '0)
        && ({1'b0, in_q.row_index} < in_q.rect_height);
    ok_y = !py_s[CoordWidth]
        && (py_s[CoordWidth-1:0] < {2'b00, cfg_i.fb_height});

    if (in_q.rect_x[CoordWidth-1]) begin
      x0 = '0;
    end else if (in_q.rect_x > {2'b00, cfg_i.fb_width}) begin
      x0 = cfg_i.fb_width;
    end else begin
      x0 = in_q.rect_x[DimWidth-1:0];
    end

    if (xe_s[CoordWidth]) begin
      x1 = '0;
    end else if (xe_s[CoordWidth-1:0] > {2'b00, cfg_i.fb_width}) begin
      x1 = cfg_i.fb_width;
    end else begin
      x1 = xe_s[DimWidth-1:0];
    end

    ok_x = x1 > x0;

    clip_d.ok  = ok_h && ok_y && ok_x;
    clip_d.py  = py_s[DimWidth-1:0];
    clip_d.x0  = x0;
    clip_d.len = x1 - x0;
    if (!in_q.rect_height[CoordWidth-1] && (in_q.rect_height[RowWidth-1:0] > 15'd1)) begin
      clip_d.dvs = in_q.rect_height[RowWidth-1:0] - 15'd1;
    end else begin
      clip_d.dvs = 15'd1;
    end
    clip_d.row          = in_q.row_index;
    clip_d.top_color    = in_q.top_color;
    clip_d.bottom_color = in_q.bottom_color;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      clip_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        in_valid_q <= valid_i;
      end
      if (clip_ready) begin
        clip_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      in_q <= data_i;
    end
    if (clip_ready && in_valid_q) begin
      clip_q <= clip_d;
    end
  end

  assign valid_o = clip_valid_q;
  assign data_o  = clip_q;

endmodule

FILE: hw/rtl/grsg_mul.sv
// Multiply stage: scanline address and the per-channel dividend of the blend.
// Depends on grsg_pkg for the configuration, clip and divider types.
module grsg_mul (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  grsg_pkg::cfg_t  cfg_i,
  input  logic           valid_i,
  output logic           ready_o,
  input  grsg_pkg::clip_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output grsg_pkg::div_t  data_o
);
  import grsg_pkg::*;

  logic  valid_q;
  div_t  div_d, div_q;

  logic [2*DimWidth-1:0]                 prod;
  logic [2*DimWidth-1:0]                 sum;
  logic [NumChannels-1:0][ChanWidth-1:0] c0;
  logic [NumChannels-1:0][ChanWidth-1:0] c1;
  logic [NumChannels-1:0][ChanWidth-1:0] mag;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    prod = (2*DimWidth)'(data_i.py) * (2*DimWidth)'(cfg_i.line_stride);
    sum  = prod + {{DimWidth{1'b0}}, data_i.x0};

    div_d.ok        = data_i.ok;
    div_d.addr      = sum[AddrWidth-1:0];
    div_d.len       = data_i.len;
    div_d.top_color = data_i.top_color;
    div_d.dvs       = data_i.dvs;
    div_d.quo       = '0;
    for (int ch = 0; ch < NumChannels; ch++) begin
      c0[ch]          = data_i.top_color[ch*ChanWidth +: ChanWidth];
      c1[ch]          = data_i.bottom_color[ch*ChanWidth +: ChanWidth];
      div_d.neg[ch]   = c1[ch] < c0[ch];
      mag[ch]         = div_d.neg[ch] ? (c0[ch] - c1[ch]) : (c1[ch] - c0[ch]);
      div_d.rem[ch]   = NumWidth'(mag[ch]) * NumWidth'(data_i.row);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = div_q;

endmodule

FILE: hw/rtl/grsg_div_step.sv
// One restoring-division stage: settles one quotient bit for all three channels.
// Depends on grsg_pkg for the divider payload type.
module grsg_div_step #(
  parameter int unsigned Bit = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  grsg_pkg::div_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output grsg_pkg::div_t data_o
);
  import grsg_pkg::*;

  logic  valid_q;
  div_t  div_d, div_q;

  logic [RemWidth-1:0]                   shifted;
  logic [NumChannels-1:0][RemWidth-1:0]  trial;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    div_d   = data_i;
    shifted = RemWidth'(data_i.dvs) << Bit;
    for (int ch = 0; ch < NumChannels; ch++) begin
      trial[ch] = {1'b0, data_i.rem[ch]} - shifted;
      if (!trial[ch][RemWidth-1]) begin
        div_d.rem[ch]      = trial[ch][NumWidth-1:0];
        div_d.quo[ch][Bit] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = div_q;

endmodule

FILE: hw/rtl/grsg_out.sv
// Output stage: applies the signed quotient to the top color and forms the span.
// Depends on grsg_pkg for the divider payload and span types.
module grsg_out (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  grsg_pkg::div_t  data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output grsg_pkg::span_t data_o
);
  import grsg_pkg::*;

  logic   valid_q;
  span_t  span_d, span_q;

  logic [NumChannels-1:0][ChanWidth-1:0] c0;
  logic [NumChannels-1:0][ChanWidth-1:0] col;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    for (int ch = 0; ch < NumChannels; ch++) begin
      c0[ch]  = data_i.top_color[ch*ChanWidth +: ChanWidth];
      col[ch] = data_i.neg[ch] ? (c0[ch] - data_i.quo[ch]) : (c0[ch] + data_i.quo[ch]);
    end
    if (data_i.ok) begin
      span_d.span_valid    = 1'b1;
      span_d.start_address = data_i.addr;
      span_d.span_length   = data_i.len;
      span_d.row_color     = col;
    end else begin
      span_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      span_q <= span_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = span_q;

endmodule

FILE: hw/rtl/grsg_chk.sv
// Port-level checker for the gradient row span generator, bound to the top level.
// Depends only on the top-level port names.
module grsg_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("Stalled output transaction changed or dropped.");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 64'd0)
    else $error("Invalid span carries nonzero fields.");

  a_valid_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[39:26] != 14'd0)
    else $error("Valid span has zero length.");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("Output valid during reset.");

endmodule

bind gradient_row_span_generator grsg_chk u_grsg_chk (.*);

FILE: bench/grsg_span_checker.sv
`timescale 1ns / 100ps
// Checker for the gradient row span generator: watches the rectangle, span and
// configuration channels, predicts each span and compares it field by field.
// Depends on grsg_pkg for field widths, register codes and reset geometry.
module grsg_span_checker #(
  parameter int unsigned FbMaxDim = 8192
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [grsg_pkg::InDataWidth-1:0]  s_axis_tdata,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [grsg_pkg::OutDataWidth-1:0] m_axis_tdata,
  input  logic                              m_axis_tuser,
  input  logic                              cfg_we_i,
  input  logic [grsg_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [grsg_pkg::DimWidth-1:0]     cfg_wdata_i,
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                visible_o
);
  import grsg_pkg::*;

  cfg_t  geometry;
  span_t expected_spans[$];
  int    fails = 0;
  int    visible = 0;

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: span mismatch in %s, got 0x%0h, expected 0x%0h", $time, field,
             got, want);
    fails++;
  endtask

  function automatic int fence(input int v, input int hi);
    return (v < 0) ? 0 : ((v > hi) ? hi : v);
  endfunction

  function automatic span_t compute_span(input rect_t r, input cfg_t g);
    span_t s;
    int x, y, w, h, j, py, x0, x1, dvs, c0, c1, k;
    s = '0;
    x = int'($signed(r.rect_x));
    y = int'($signed(r.rect_y));
    w = int'($signed(r.rect_width));
    h = int'($signed(r.rect_height));
    j = int'(r.row_index);
    py = y + j;
    x0 = fence(x, int'(g.fb_width));
    x1 = fence(x + w, int'(g.fb_width));
    if (h > 0 && j < h && py >= 0 && py < int'(g.fb_height) && x1 > x0) begin
      dvs = (h > 1) ? h - 1 : 1;
      s.span_valid = 1'b1;
      s.start_address = AddrWidth'(py * int'(g.line_stride) + x0);
      s.span_length = DimWidth'(x1 - x0);
      for (k = 0; k < NumChannels; k++) begin
        c0 = int'(r.top_color[k*ChanWidth +: ChanWidth]);
        c1 = int'(r.bottom_color[k*ChanWidth +: ChanWidth]);
        // Signed division truncates toward zero, as a falling channel needs.
        s.row_color[k*ChanWidth +: ChanWidth] = ChanWidth'(c0 + ((c1 - c0) * j) / dvs);
      end
    end
    return s;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rect_t               req;
    span_t               got;
    span_t               want;
    logic [DimWidth-1:0] dim;
    if (!rst_ni) begin
      geometry = '{fb_width: FbWidthRst, fb_height: FbHeightRst,
                   line_stride: LineStrideRst};
      expected_spans.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.start_address = m_axis_tdata[0 +: AddrWidth];
        got.span_length = m_axis_tdata[AddrWidth +: DimWidth];
        got.row_color = m_axis_tdata[AddrWidth+DimWidth +: ColorWidth];
        got.span_valid = m_axis_tuser;
        if (expected_spans.size() == 0) begin
          report_mismatch("span with no rectangle pending", m_axis_tdata, '0);
        end else begin
          want = expected_spans.pop_front();
          if (got.span_valid) visible++;
          if (got.span_valid !== want.span_valid)
            report_mismatch("span_valid", 64'(got.span_valid), 64'(want.span_valid));
          if (got.start_address !== want.start_address)
            report_mismatch("start_address", 64'(got.start_address),
                            64'(want.start_address));
          if (got.span_length !== want.span_length)
            report_mismatch("span_length", 64'(got.span_length), 64'(want.span_length));
          if (got.row_color !== want.row_color)
            report_mismatch("row_color", 64'(got.row_color), 64'(want.row_color));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        req.rect_x = s_axis_tdata[0 +: CoordWidth];
        req.rect_y = s_axis_tdata[CoordWidth +: CoordWidth];
        req.rect_width = s_axis_tdata[2*CoordWidth +: CoordWidth];
        req.rect_height = s_axis_tdata[3*CoordWidth +: CoordWidth];
        req.top_color = s_axis_tdata[4*CoordWidth +: ColorWidth];
        req.bottom_color = s_axis_tdata[4*CoordWidth+ColorWidth +: ColorWidth];
        req.row_index = s_axis_tdata[4*CoordWidth+2*ColorWidth +: RowWidth];
        expected_spans.push_back(compute_span(req, geometry));
      end
      if (cfg_we_i) begin
        dim = (cfg_wdata_i > FbMaxDim) ? DimWidth'(FbMaxDim) : cfg_wdata_i;
        case (cfg_idx_i)
          CfgFbWidth: geometry.fb_width = dim;
          CfgFbHeight: geometry.fb_height = dim;
          CfgLineStride: geometry.line_stride = dim;
          default: ;
        endcase
      end
    end
    fail_count_o <= fails;
    pending_o <= expected_spans.size();
    visible_o <= visible;
  end

endmodule

FILE: bench/gradient_row_span_generator_tb.sv
`timescale 1ns / 100ps
// Top of the gradient row span generator testbench: clock, reset, stimulus,
// configuration phases and verdict. Depends on grsg_pkg and grsg_span_checker.
module gradient_row_span_generator_tb;
  import grsg_pkg::*;

  localparam int unsigned             FbMaxDim       = 8192;
  localparam logic [CfgIdxWidth-1:0]  CfgUnused      = 2'd3;
  localparam int                      CycleLimit     = 200_000;
  localparam int                      SettleCycles   = 20;
  localparam int                      LongHoldCycles = 300;
  localparam int                      PressureItems  = 60;
  localparam int                      NumPhases      = 9;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic                    m_axis_tuser;
  logic                    cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_idx_i = CfgFbWidth;
  logic [DimWidth-1:0]     cfg_wdata_i = '0;

  int fail_count;
  int pending;
  int visible;

  int cycle_count = 0;
  int src_idle_pct = 30;
  int sink_idle_pct = 48;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;
  int span_w = 640;
  int span_h = 480;
  int rows_sent = 0;

  gradient_row_span_generator #(
    .FbMaxDim(FbMaxDim)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  grsg_span_checker #(
    .FbMaxDim(FbMaxDim)
  ) span_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .visible_o    (visible)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Run timed out after %0d cycles.", CycleLimit);
      $display("FAILURE");
      $finish;
    end
  end

  // The span receiver; it takes one long hold-off when asked, counting it here.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= LongHoldCycles;
      hold_done <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  function automatic rect_t make_rect(input int x, input int y, input int w, input int h,
                                      input int top, input int bottom, input int j);
    rect_t r;
    r.rect_x = CoordWidth'(x);
    r.rect_y = CoordWidth'(y);
    r.rect_width = CoordWidth'(w);
    r.rect_height = CoordWidth'(h);
    r.top_color = ColorWidth'(top);
    r.bottom_color = ColorWidth'(bottom);
    r.row_index = RowWidth'(j);
    return r;
  endfunction

  // Mostly rows that land near the visible area, with the rest left fully random.
  function automatic rect_t random_rect();
    rect_t r;
    int x, y, w, h, j;
    r = make_rect($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    if ($urandom_range(99) < 20) return r;
    h = ($urandom_range(7) == 0) ? int'($urandom_range(32767, 1))
                                 : int'($urandom_range(span_h + 8, 1));
    j = ($urandom_range(9) == 0) ? int'($urandom_range(32767)) : int'($urandom_range(h - 1));
    y = int'($urandom_range(span_h + 8)) - j - 4;
    x = int'($urandom_range(2 * span_w + 40)) - span_w / 2 - 20;
    w = ($urandom_range(9) == 0) ? int'($urandom_range(32767))
                                 : int'($urandom_range(span_w + 20)) - 4;
    r = make_rect(x, y, w, h, int'(r.top_color), int'(r.bottom_color), j);
    if ($urandom_range(4) == 0) begin
      r.bottom_color = r.top_color;
    end else if ($urandom_range(9) == 0) begin
      r.top_color = $urandom_range(1) ? '1 : '0;
      r.bottom_color = ~r.top_color;
    end
    return r;
  endfunction

  task automatic send_rect(input rect_t r);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, r.row_index, r.bottom_color, r.top_color, r.rect_height,
                     r.rect_width, r.rect_y, r.rect_x};
    do @(posedge clk_i); while (!s_axis_tready);
    rows_sent++;
  endtask

  task automatic drain_spans();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic load_geometry(input int fbw, input int fbh, input int stride);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgFbWidth;
    cfg_wdata_i <= DimWidth'(fbw);
    @(posedge clk_i);
    cfg_idx_i <= CfgFbHeight;
    cfg_wdata_i <= DimWidth'(fbh);
    @(posedge clk_i);
    cfg_idx_i <= CfgLineStride;
    cfg_wdata_i <= DimWidth'(stride);
    @(posedge clk_i);
    cfg_idx_i <= CfgUnused;
    cfg_wdata_i <= DimWidth'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    span_w = (fbw > FbMaxDim) ? FbMaxDim : ((fbw < 1) ? 1 : fbw);
    span_h = (fbh > FbMaxDim) ? FbMaxDim : ((fbh < 1) ? 1 : fbh);
  endtask

  initial begin
    int phase_items;
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry is 640 by 480 with a 640 pixel stride.
    send_rect(make_rect(10, 20, 100, 50, 'h123456, 'h123456, 0));
    send_rect(make_rect(0, 0, 640, 256, 'h000000, 'hFFFFFF, 0));
    send_rect(make_rect(0, 0, 640, 256, 'h000000, 'hFFFFFF, 255));
    send_rect(make_rect(5, 100, 30, 256, 'hFFFFFF, 'h000000, 128));
    send_rect(make_rect(5, 100, 30, 256, 'hFF00FF, 'h00FF00, 77));
    send_rect(make_rect(5, 7, 30, 1, 'h102030, 'hF0E0D0, 0));
    send_rect(make_rect(5, 7, 30, 0, 'h102030, 'hF0E0D0, 0));
    send_rect(make_rect(5, 7, 30, -5, 'h102030, 'hF0E0D0, 0));
    send_rect(make_rect(5, 7, 30, 10, 'h102030, 'hF0E0D0, 10));
    send_rect(make_rect(5, 7, 0, 10, 'h102030, 'hF0E0D0, 3));
    send_rect(make_rect(5, 7, -32768, 10, 'h102030, 'hF0E0D0, 3));
    send_rect(make_rect(-50, 7, 100, 10, 'hABCDEF, 'h012345, 4));
    send_rect(make_rect(600, 7, 100, 10, 'hABCDEF, 'h012345, 9));
    send_rect(make_rect(-200, 7, 100, 10, 'hABCDEF, 'h012345, 2));
    send_rect(make_rect(640, 7, 100, 10, 'hABCDEF, 'h012345, 2));
    send_rect(make_rect(32767, 32767, 32767, 32767, 'hFFFFFF, 'hFFFFFF, 32767));
    send_rect(make_rect(-32768, -32768, 32767, 32767, 'h000000, 'hFFFFFF, 32766));
    send_rect(make_rect(0, -32000, 640, 32767, 'h00FF80, 'hFF0080, 32200));
    send_rect(make_rect(3, -10, 20, 8, 'h334455, 'h554433, 5));
    send_rect(make_rect(3, 479, 20, 8, 'h334455, 'h554433, 0));
    send_rect(make_rect(3, 480, 20, 8, 'h334455, 'h554433, 0));
    send_rect(make_rect(3, 472, 20, 8, 'h334455, 'h554433, 7));
    send_rect(make_rect(0, 200, 640, 3, 'hFFFFFF, 'h000000, 1));
    drain_spans();

    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: load_geometry(8192, 8192, 8192);
        1: load_geometry(1, 1, 1);
        2: load_geometry(16383, 9000, 12000);
        3: load_geometry(0, 300, 100);
        4: load_geometry(200, 0, 50);
        5: load_geometry($urandom_range(8192, 1), $urandom_range(8192, 1),
                         $urandom_range(8192, 1));
        6, 7: load_geometry($urandom_range(1024, 16), $urandom_range(1024, 16),
                            $urandom_range(1024, 16));
        default: load_geometry(640, 480, 1000);
      endcase
      if (phase < 3) begin
        src_idle_pct = 30;
        sink_idle_pct <= 48;
      end else if (phase < 6) begin
        src_idle_pct = 48;
        sink_idle_pct <= 30;
      end else begin
        src_idle_pct = 0;
        sink_idle_pct <= 0;
      end
      phase_items = (phase == 1 || phase == 3 || phase == 4) ? 40 : 180;
      if (phase == NumPhases - 1) begin
        // The receiver stalls long enough for the pipe to back up into the input.
        hold_req <= 1'b1;
        repeat (PressureItems) send_rect(random_rect());
      end
      repeat (phase_items) send_rect(random_rect());
      drain_spans();
    end

    $display("Sent %0d rectangle rows over %0d framebuffer geometries; %0d gave visible spans.",
             rows_sent, NumPhases + 1, visible);
    $display("Covered clipping on every edge, flat and falling gradients, degenerate and "
             , "saturating geometry, and a long output stall.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/grsg_pkg.sv
hw/rtl/grsg_clip.sv
hw/rtl/grsg_mul.sv
hw/rtl/grsg_div_step.sv
hw/rtl/grsg_out.sv
hw/rtl/gradient_row_span_generator.sv
hw/rtl/grsg_chk.sv
bench/grsg_span_checker.sv
bench/gradient_row_span_generator_tb.sv
